// File: hdl/sdcd_pkg.sv
package sdcd_pkg;

    localparam int unsigned DAY_W   = 17;
    localparam int unsigned LEN_W   = 9;
    localparam int unsigned YOFS_W  = 8;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DOM_W   = 5;
    localparam int unsigned YEAR_W  = 12;

    localparam logic [YEAR_W-1:0]  FIRST_YEAR = 12'd1900;
    localparam logic [YEAR_W-1:0]  LAST_YEAR  = 12'd2099;
    // years covered, 1900 through 2099
    localparam logic [YOFS_W-1:0]  YEAR_SPAN  = 8'd200;
    // offsets of the century years that are not leap years
    localparam logic [YOFS_W-1:0]  YOFS_1900  = 8'd0;
    localparam logic [YOFS_W-1:0]  YOFS_2100  = 8'd200;
    localparam logic [MONTH_W-1:0] MIDX_FEB   = 4'd1;
    localparam logic [MONTH_W-1:0] MIDX_APR   = 4'd3;
    localparam logic [MONTH_W-1:0] MIDX_JUN   = 4'd5;
    localparam logic [MONTH_W-1:0] MIDX_SEP   = 4'd8;
    localparam logic [MONTH_W-1:0] MIDX_NOV   = 4'd10;
    localparam logic [MONTH_W-1:0] MIDX_DEC   = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
    localparam logic [DOM_W-1:0]   DOM_LAST   = 5'd31;
    localparam logic [LEN_W-1:0]   LEN_YEAR   = 9'd365;
    localparam logic [LEN_W-1:0]   LEN_LEAP   = 9'd366;

    typedef struct packed {
        logic [DAY_W-1:0] diff;
        logic             fits;
    } sub_res_t;

    // Leap rule over 1900..2100 expressed on the year offset from 1900:
    // divisible by 4, except 1900 and 2100 (2000 stays a leap year).
    function automatic logic is_leap(input logic [YOFS_W-1:0] yofs);
        return (yofs[1:0] == 2'b00) && (yofs != YOFS_1900) && (yofs != YOFS_2100);
    endfunction

    function automatic logic [LEN_W-1:0] month_len(input logic [MONTH_W-1:0] midx,
                                                   input logic leap);
        logic [LEN_W-1:0] len;
        unique case (midx)
            MIDX_FEB: len = leap ? 9'd29 : 9'd28;
            MIDX_APR, MIDX_JUN, MIDX_SEP, MIDX_NOV: len = 9'd30;
            default: len = 9'd31;
        endcase
        return len;
    endfunction

endpackage

// File: hdl/sdcd_sub_unit.sv
module sdcd_sub_unit (
    input  logic [sdcd_pkg::DAY_W-1:0] left,
    input  logic [sdcd_pkg::LEN_W-1:0] len,
    output sdcd_pkg::sub_res_t         res
);

    logic [sdcd_pkg::DAY_W-1:0] len_ext;

    assign len_ext  = {{(sdcd_pkg::DAY_W-sdcd_pkg::LEN_W){1'b0}}, len};
    assign res.diff = left - len_ext;
    assign res.fits = (left <= len_ext);

endmodule

// File: hdl/serial_day_to_calendar_date_core.sv
// Channel   Direction  Ports
// s_        input      s_valid, s_ready, s_day_number
// m_        output     m_valid, m_ready, m_year_out, m_month_out, m_day_out
//
// A beat is accepted in ST_IDLE; ST_YEAR then tests one year at a time (each removed
// year, at most 200, plus the final fit or saturation test), ST_MONTH tests one month
// at a time (at most 12 tests) and ST_DONE loads the result register. All tests use
// the single shared subtract/compare unit, so no new beat is accepted until the core
// is back in ST_IDLE; m_valid rises as the result register is loaded.
// aresetn is synchronous, active low, and clears the sequencer and m_valid.
// A result waits in the output register; the next beat may be accepted and
// processed meanwhile, and holds in the final state until the register frees.
module serial_day_to_calendar_date_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [sdcd_pkg::DAY_W-1:0]   s_day_number,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [sdcd_pkg::YEAR_W-1:0]  m_year_out,
    output logic [sdcd_pkg::MONTH_W-1:0] m_month_out,
    output logic [sdcd_pkg::DOM_W-1:0]   m_day_out
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_YEAR  = 4'b0010,
        ST_MONTH = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t                        state_reg, state_next;
    logic [sdcd_pkg::DAY_W-1:0]    left_reg, left_next;
    logic [sdcd_pkg::YOFS_W-1:0]   yofs_reg, yofs_next;
    logic [sdcd_pkg::MONTH_W-1:0]  midx_reg, midx_next;
    logic                          sat_reg, sat_next;
    logic                          m_valid_reg, m_valid_next;
    logic [sdcd_pkg::YEAR_W-1:0]   year_reg, year_next;
    logic [sdcd_pkg::MONTH_W-1:0]  month_reg, month_next;
    logic [sdcd_pkg::DOM_W-1:0]    dom_reg, dom_next;

    logic [sdcd_pkg::LEN_W-1:0]    unit_len;
    sdcd_pkg::sub_res_t            unit_res;
    logic                          leap;
    logic                          out_free;

    assign leap     = sdcd_pkg::is_leap(yofs_reg);
    assign unit_len = (state_reg == ST_YEAR)
                      ? (leap ? sdcd_pkg::LEN_LEAP : sdcd_pkg::LEN_YEAR)
                      : sdcd_pkg::month_len(midx_reg, leap);

    sdcd_sub_unit u_sub (
        .left (left_reg),
        .len  (unit_len),
        .res  (unit_res)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        left_next    = left_reg;
        yofs_next    = yofs_reg;
        midx_next    = midx_reg;
        sat_next     = sat_reg;
        m_valid_next = m_valid_reg;
        year_next    = year_reg;
        month_next   = month_reg;
        dom_next     = dom_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    // zero maps onto the first day
                    left_next  = (s_day_number == '0) ? {{(sdcd_pkg::DAY_W-1){1'b0}}, 1'b1}
                                                       : s_day_number;
                    yofs_next  = '0;
                    midx_next  = '0;
                    sat_next   = 1'b0;
                    state_next = ST_YEAR;
                end
            end
            ST_YEAR: begin
                if (yofs_reg >= sdcd_pkg::YEAR_SPAN) begin
                    sat_next   = 1'b1;
                    state_next = ST_DONE;
                end else if (unit_res.fits) begin
                    state_next = ST_MONTH;
                end else begin
                    left_next = unit_res.diff;
                    yofs_next = yofs_reg + 1'b1;
                end
            end
            ST_MONTH: begin
                if ((midx_reg == sdcd_pkg::MIDX_DEC) || unit_res.fits) begin
                    state_next = ST_DONE;
                end else begin
                    left_next = unit_res.diff;
                    midx_next = midx_reg + 1'b1;
                end
            end
            ST_DONE: begin
                // hold until the output register frees
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (sat_reg) begin
                        year_next  = sdcd_pkg::LAST_YEAR;
                        month_next = sdcd_pkg::MONTH_DEC;
                        dom_next   = sdcd_pkg::DOM_LAST;
                    end else begin
                        year_next  = sdcd_pkg::FIRST_YEAR
                                     + {{(sdcd_pkg::YEAR_W-sdcd_pkg::YOFS_W){1'b0}}, yofs_reg};
                        month_next = midx_reg + 1'b1;
                        dom_next   = left_reg[sdcd_pkg::DOM_W-1:0];
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        left_reg  <= left_next;
        yofs_reg  <= yofs_next;
        midx_reg  <= midx_next;
        sat_reg   <= sat_next;
        year_reg  <= year_next;
        month_reg <= month_next;
        dom_reg   <= dom_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_year_out  = year_reg;
    assign m_month_out = month_reg;
    assign m_day_out   = dom_reg;

endmodule

// File: dv/tb_serial_day_to_calendar_date_core.sv
`timescale 1ns / 100ps

module tb_serial_day_to_calendar_date_core;

    import sdcd_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned TAIL_CYCLES    = 250;
    localparam int unsigned RANDOM_DAYS    = 1400;
    localparam int unsigned LAST_SERIAL    = 73049;
    localparam int unsigned MAX_SERIAL     = (1 << DAY_W) - 1;
    localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30,
                                                31, 31, 30, 31, 30, 31};

    typedef struct {
        logic [DAY_W-1:0] serial;
        bit               drain_first;
    } day_req_t;

    typedef struct {
        logic [DAY_W-1:0]   serial;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DOM_W-1:0]   day;
    } cal_date_t;

    logic               aclk         = 1'b0;
    logic               aresetn      = 1'b0;
    logic               s_valid      = 1'b0;
    logic               s_ready;
    logic [DAY_W-1:0]   s_day_number = '0;
    logic               m_valid;
    logic               m_ready      = 1'b0;
    logic [YEAR_W-1:0]  m_year_out;
    logic [MONTH_W-1:0] m_month_out;
    logic [DOM_W-1:0]   m_day_out;

    day_req_t    pending_days[$];
    cal_date_t   expected_dates[$];
    cal_date_t   want;
    int unsigned err_count   = 0;
    int unsigned idle_cycles = 0;
    int unsigned tx_burst    = 0;
    int unsigned tx_gap      = 0;
    int unsigned rx_cycle    = 0;
    int unsigned rx_mode     = 0;
    bit          timed_out   = 1'b0;

    serial_day_to_calendar_date_core u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_day_number(s_day_number),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_year_out  (m_year_out),
        .m_month_out (m_month_out),
        .m_day_out   (m_day_out)
    );

    always #5 aclk = ~aclk;

    function automatic bit is_leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned year_days(input int unsigned y);
        return is_leap_year(y) ? 366 : 365;
    endfunction

    function automatic int unsigned month_days(input int unsigned mo, input int unsigned y);
        return (mo == 2 && is_leap_year(y)) ? 29 : MONTH_DAYS[mo-1];
    endfunction

    // serial number of January 1st of year y
    function automatic int unsigned jan_first(input int unsigned y);
        int unsigned s;
        s = 1;
        for (int unsigned k = 1900; k < y; k++)
            s += year_days(k);
        return s;
    endfunction

    function automatic cal_date_t serial_to_date(input logic [DAY_W-1:0] serial);
        cal_date_t   d;
        int unsigned left;
        int unsigned yr;
        int unsigned mo;
        d.serial = serial;
        d.year   = FIRST_YEAR;
        d.month  = 4'd1;
        d.day    = 5'd1;
        left     = serial;
        yr       = FIRST_YEAR;
        if (left >= 1) begin
            while (yr <= LAST_YEAR && left > year_days(yr)) begin
                left -= year_days(yr);
                yr++;
            end
            if (yr > LAST_YEAR) begin
                // saturate past the last covered year
                d.year  = LAST_YEAR;
                d.month = MONTH_DEC;
                d.day   = DOM_LAST;
            end else begin
                mo = 1;
                while (mo < 12 && left > month_days(mo, yr)) begin
                    left -= month_days(mo, yr);
                    mo++;
                end
                d.year  = YEAR_W'(yr);
                d.month = MONTH_W'(mo);
                d.day   = DOM_W'(left);
            end
        end
        return d;
    endfunction

    task automatic queue_day(input int unsigned serial, input bit drain_first);
        day_req_t r;
        r.serial      = DAY_W'(serial);
        r.drain_first = drain_first;
        pending_days.push_back(r);
    endtask

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= 40)
            $display("%0t ns: %s", $time, msg);
    endtask

    function automatic int unsigned random_serial();
        int unsigned pick;
        int unsigned base;
        pick = $urandom_range(0, 15);
        case (pick)
            0, 1: return $urandom_range(0, MAX_SERIAL);
            2: return $urandom_range(0, 400);
            3, 4, 5: begin
                // land on year, February and March edges
                base = jan_first($urandom_range(FIRST_YEAR, LAST_YEAR));
                case ($urandom_range(0, 4))
                    0: return base - 1;
                    1: return base;
                    2: return base + 58;
                    3: return base + 59;
                    default: return base + 60;
                endcase
            end
            6: return $urandom_range(LAST_SERIAL - 60, LAST_SERIAL + 60);
            default: return $urandom_range(1, LAST_SERIAL);
        endcase
    endfunction

    // sender: bursts of beats separated by random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_dates.push_back(serial_to_date(s_day_number));
                if (tx_burst > 0)
                    tx_burst--;
                if (tx_burst == 0) begin
                    tx_burst = $urandom_range(1, 24);
                    tx_gap   = ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(1, 12);
                end
            end
            if (!s_valid || s_ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_valid <= 1'b0;
                end else if (pending_days.size() > 0 &&
                             (!pending_days[0].drain_first || expected_dates.size() == 0)) begin
                    s_valid      <= 1'b1;
                    s_day_number <= pending_days[0].serial;
                    void'(pending_days.pop_front());
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: check each beat, stall in modes picked anew at random as rx_cycle counts on
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_dates.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %0d-%0d-%0d",
                                              m_year_out, m_month_out, m_day_out));
                end else begin
                    want = expected_dates.pop_front();
                    if (m_year_out !== want.year)
                        report_mismatch($sformatf("day %0d: year %0d, want %0d",
                                                  want.serial, m_year_out, want.year));
                    if (m_month_out !== want.month)
                        report_mismatch($sformatf("day %0d: month %0d, want %0d",
                                                  want.serial, m_month_out, want.month));
                    if (m_day_out !== want.day)
                        report_mismatch($sformatf("day %0d: day %0d, want %0d",
                                                  want.serial, m_day_out, want.day));
                end
            end
            rx_cycle++;
            if (rx_cycle % 128 == 0)
                rx_mode = $urandom_range(0, 3);
            case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                2: m_ready <= (rx_cycle % 7 == 0);
                default: m_ready <= ($urandom_range(0, 15) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        int unsigned y1904;
        int unsigned y2000;
        int unsigned y2096;
        y1904 = jan_first(1904);
        y2000 = jan_first(2000);
        y2096 = jan_first(2096);

        queue_day(0, 1'b0);
        queue_day(1, 1'b0);
        queue_day(2, 1'b0);
        queue_day(31, 1'b0);
        queue_day(32, 1'b0);
        queue_day(59, 1'b0);
        queue_day(60, 1'b0);
        queue_day(365, 1'b0);
        queue_day(366, 1'b0);
        queue_day(y1904 + 59, 1'b0);
        queue_day(y1904 + 60, 1'b0);
        queue_day(y2000 - 1, 1'b0);
        queue_day(y2000 + 58, 1'b0);
        queue_day(y2000 + 59, 1'b0);
        queue_day(y2000 + 60, 1'b0);
        queue_day(y2096 + 59, 1'b0);
        queue_day(jan_first(2099), 1'b0);
        queue_day(LAST_SERIAL - 1, 1'b0);
        queue_day(LAST_SERIAL, 1'b0);
        queue_day(LAST_SERIAL + 1, 1'b0);
        queue_day(65535, 1'b0);
        queue_day(65536, 1'b0);
        queue_day(MAX_SERIAL - 1, 1'b0);
        queue_day(MAX_SERIAL, 1'b0);
        // hold the random part until the directed results are all back
        for (int unsigned i = 0; i < RANDOM_DAYS; i++)
            queue_day(random_serial(), (i % 400) == 0);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (!timed_out &&
               !(pending_days.size() == 0 && !s_valid && expected_dates.size() == 0)) begin
            @(negedge aclk);
            if (idle_cycles >= WATCHDOG_LIMIT)
                timed_out = 1'b1;
        end
        if (!timed_out) begin
            repeat (TAIL_CYCLES) @(negedge aclk);
            if (expected_dates.size() != 0)
                report_mismatch($sformatf("%0d results never arrived", expected_dates.size()));
        end

        if (timed_out) begin
            $display("tb_serial_day_to_calendar_date_core: done, errors");
        end else if (err_count == 0) begin
            $display("tb_serial_day_to_calendar_date_core: done, clean");
        end else begin
            $display("tb_serial_day_to_calendar_date_core: done, errors");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/sdcd_pkg.sv
hdl/sdcd_sub_unit.sv
hdl/serial_day_to_calendar_date_core.sv
dv/tb_serial_day_to_calendar_date_core.sv
